FILE: hdl/utf8s_pkg.sv
// ---------------------------------------------------------------------------
// utf8s_pkg
// Constants, types and helpers shared by the UTF-8 sanitiser modules.
// ---------------------------------------------------------------------------
package utf8s_pkg;

	// Replacement character U+FFFD in UTF-8.
	localparam logic [7:0] REPL_B0 = 8'hEF;
	localparam logic [7:0] REPL_B1 = 8'hBF;
	localparam logic [7:0] REPL_B2 = 8'hBD;

	localparam logic [7:0] ASCII_LIMIT = 8'h80;
	localparam logic [7:0] CONT_MASK   = 8'hC0;
	localparam logic [7:0] CONT_CODE   = 8'h80;
	localparam logic [7:0] LEAD2_MASK  = 8'hE0;
	localparam logic [7:0] LEAD2_CODE  = 8'hC0;
	localparam logic [7:0] LEAD3_MASK  = 8'hF0;
	localparam logic [7:0] LEAD3_CODE  = 8'hE0;
	localparam logic [7:0] LEAD4_MASK  = 8'hF8;
	localparam logic [7:0] LEAD4_CODE  = 8'hF0;

	localparam int unsigned HELD_DEPTH = 3;

	// Position of the last byte within a replacement sequence.
	localparam logic [1:0] PHASE_LAST = 2'd2;

	typedef enum logic [1:0] {
		SEL_REP,
		SEL_HELD,
		SEL_BYTE
	} emit_sel_t;

	// Controller to datapath.
	typedef struct packed {
		logic       accept;
		logic       load;
		emit_sel_t  sel;
		logic [1:0] rep_phase;
		logic [1:0] held_idx;
		logic       final_item;
	} utf8s_cmd_t;

	// Datapath to controller: latest item's emission plan and output stall.
	typedef struct packed {
		logic [2:0] rep_cnt;
		logic [1:0] held_n;
		logic       pass_b;
		logic       out_stall;
	} utf8s_status_t;

	// Sequence length announced by a lead byte, zero when it is not a lead.
	function automatic logic [2:0] seq_len(input logic [7:0] b);
		logic [2:0] len;
		len = 3'd0;
		if ((b & LEAD2_MASK) == LEAD2_CODE)
			len = 3'd2;
		else if ((b & LEAD3_MASK) == LEAD3_CODE)
			len = 3'd3;
		else if ((b & LEAD4_MASK) == LEAD4_CODE)
			len = 3'd4;
		return len;
	endfunction

endpackage

FILE: hdl/utf8s_in_if.sv
// ---------------------------------------------------------------------------
// utf8s_in_if
// Input channel: one raw byte of the text stream per item.
// ---------------------------------------------------------------------------
interface utf8s_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_stream;

	modport source (output valid, data_byte, end_of_stream, input ready);
	modport sink   (input valid, data_byte, end_of_stream, output ready);
endinterface

FILE: hdl/utf8s_out_if.sv
// ---------------------------------------------------------------------------
// utf8s_out_if
// Output channel: one byte of the sanitised stream per item.
// ---------------------------------------------------------------------------
interface utf8s_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       final_byte;
	logic       any_replaced;

	modport source (output valid, out_byte, final_byte, any_replaced, input ready);
	modport sink   (input valid, out_byte, final_byte, any_replaced, output ready);
endinterface

FILE: hdl/utf8s_datapath.sv
// ---------------------------------------------------------------------------
// utf8s_datapath
// Sequence state, held bytes, emission plan and the output register.
// ---------------------------------------------------------------------------
module utf8s_datapath (
	input  logic                    clk,
	input  logic                    arst_n,
	input  utf8s_pkg::utf8s_cmd_t   cmd,
	output utf8s_pkg::utf8s_status_t status,
	input  logic [7:0]              data_byte,
	input  logic                    end_of_stream,
	input  logic                    out_ready,
	output logic                    out_valid,
	output logic [7:0]              out_byte,
	output logic                    final_byte,
	output logic                    any_replaced
);

	logic [7:0] held_q [utf8s_pkg::HELD_DEPTH];
	logic [1:0] hc_q;
	logic [2:0] exp_q;
	logic       seen_q;

	logic [2:0] rep_cnt_q;
	logic [1:0] held_n_q;
	logic       pass_b_q;
	logic       last_q;
	logic       flag_q;
	logic [7:0] b_q;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       final_q;
	logic       any_q;

	logic       is_cont, is_ascii, is_lead, is_bad, pending;
	logic [2:0] len;
	logic [2:0] base;
	logic [2:0] rep_n;
	logic [1:0] held_n_n;
	logic       pass_b_n;
	logic [1:0] hc_n;
	logic [2:0] exp_n;
	logic       wr_en;
	logic [1:0] wr_idx;
	logic [7:0] emit_byte;
	logic [7:0] repl_byte;

	always_comb begin
		is_cont  = (data_byte & utf8s_pkg::CONT_MASK) == utf8s_pkg::CONT_CODE;
		is_ascii = data_byte < utf8s_pkg::ASCII_LIMIT;
		len      = utf8s_pkg::seq_len(data_byte);
		is_lead  = len != 3'd0;
		is_bad   = !is_ascii && !is_lead;
		pending  = exp_q != 3'd0;
		base     = 3'd0;
		rep_n    = 3'd0;
		held_n_n = 2'd0;
		pass_b_n = 1'b0;
		hc_n     = hc_q;
		exp_n    = exp_q;
		wr_en    = 1'b0;
		wr_idx   = 2'd0;
		if (pending && is_cont) begin
			if ({1'b0, hc_q} + 3'd1 >= exp_q) begin
				// Sequence complete: the held bytes and this one go out unchanged.
				held_n_n = hc_q;
				pass_b_n = 1'b1;
				hc_n     = 2'd0;
				exp_n    = 3'd0;
			end else begin
				wr_en  = 1'b1;
				wr_idx = hc_q;
				hc_n   = hc_q + 2'd1;
				// Cut short by the end of the stream: every held byte is replaced.
				if (end_of_stream)
					rep_n = {1'b0, hc_q} + 3'd1;
			end
		end else begin
			// A broken sequence is flushed first, then the byte is taken afresh.
			if (pending)
				base = {1'b0, hc_q};
			rep_n    = base + {2'b00, is_bad} + {2'b00, is_lead && end_of_stream};
			pass_b_n = is_ascii;
			if (is_lead) begin
				wr_en  = 1'b1;
				wr_idx = 2'd0;
				hc_n   = 2'd1;
				exp_n  = len;
			end else begin
				hc_n  = 2'd0;
				exp_n = 3'd0;
			end
		end
		if (end_of_stream) begin
			hc_n  = 2'd0;
			exp_n = 3'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hc_q      <= 2'd0;
			exp_q     <= 3'd0;
			seen_q    <= 1'b0;
			rep_cnt_q <= 3'd0;
			held_n_q  <= 2'd0;
			pass_b_q  <= 1'b0;
			last_q    <= 1'b0;
			flag_q    <= 1'b0;
		end else if (cmd.accept) begin
			hc_q      <= hc_n;
			exp_q     <= exp_n;
			seen_q    <= end_of_stream ? 1'b0 : (seen_q || rep_n != 3'd0);
			rep_cnt_q <= rep_n;
			held_n_q  <= held_n_n;
			pass_b_q  <= pass_b_n;
			last_q    <= end_of_stream;
			flag_q    <= seen_q || rep_n != 3'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			b_q <= data_byte;
			if (wr_en)
				held_q[wr_idx] <= data_byte;
		end
	end

	always_comb begin
		case (cmd.rep_phase)
			2'd0:    repl_byte = utf8s_pkg::REPL_B0;
			2'd1:    repl_byte = utf8s_pkg::REPL_B1;
			default: repl_byte = utf8s_pkg::REPL_B2;
		endcase
		case (cmd.sel)
			utf8s_pkg::SEL_REP:  emit_byte = repl_byte;
			utf8s_pkg::SEL_HELD: emit_byte = held_q[cmd.held_idx];
			utf8s_pkg::SEL_BYTE: emit_byte = b_q;
			default:             emit_byte = b_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_byte_q <= emit_byte;
			final_q    <= cmd.final_item && last_q;
			any_q      <= cmd.final_item && last_q && flag_q;
		end
	end

	assign status.rep_cnt   = rep_cnt_q;
	assign status.held_n    = held_n_q;
	assign status.pass_b    = pass_b_q;
	assign status.out_stall = out_valid_q && !out_ready;

	assign out_valid    = out_valid_q;
	assign out_byte     = out_byte_q;
	assign final_byte   = final_q;
	assign any_replaced = any_q;

endmodule

FILE: hdl/utf8s_ctrl.sv
// ---------------------------------------------------------------------------
// utf8s_ctrl
// Sequencer: takes an item, walks its plan one byte a cycle unless stalled.
// ---------------------------------------------------------------------------
module utf8s_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  utf8s_pkg::utf8s_status_t status,
	output utf8s_pkg::utf8s_cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_REP,
		ST_HELD,
		ST_BYTE
	} state_t;

	state_t     state_q;
	logic [2:0] rep_left_q;
	logic [1:0] phase_q;
	logic [1:0] idx_q;

	logic       adv;
	logic       held_end;
	state_t     after_rep;
	state_t     after_held;

	always_comb begin
		adv        = !status.out_stall;
		held_end   = idx_q == status.held_n - 2'd1;
		after_held = status.pass_b ? ST_BYTE : ST_IDLE;
		after_rep  = (status.held_n != 2'd0) ? ST_HELD : after_held;

		in_ready       = state_q == ST_IDLE;
		cmd.accept     = in_ready && in_valid;
		cmd.load       = 1'b0;
		cmd.sel        = utf8s_pkg::SEL_REP;
		cmd.rep_phase  = phase_q;
		cmd.held_idx   = idx_q;
		cmd.final_item = 1'b0;
		case (state_q)
			ST_REP: begin
				cmd.load       = adv;
				cmd.final_item = phase_q == utf8s_pkg::PHASE_LAST && rep_left_q == 3'd1
					&& status.held_n == 2'd0 && !status.pass_b;
			end
			ST_HELD: begin
				cmd.load       = adv;
				cmd.sel        = utf8s_pkg::SEL_HELD;
				cmd.final_item = held_end && !status.pass_b;
			end
			ST_BYTE: begin
				cmd.load       = adv;
				cmd.sel        = utf8s_pkg::SEL_BYTE;
				cmd.final_item = 1'b1;
			end
			default: begin
				cmd.load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			rep_left_q <= 3'd0;
			phase_q    <= 2'd0;
			idx_q      <= 2'd0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.accept)
						state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					rep_left_q <= status.rep_cnt;
					phase_q    <= 2'd0;
					idx_q      <= 2'd0;
					if (status.rep_cnt != 3'd0)
						state_q <= ST_REP;
					else
						state_q <= after_rep;
				end
				ST_REP: begin
					if (adv) begin
						if (phase_q == utf8s_pkg::PHASE_LAST) begin
							phase_q    <= 2'd0;
							rep_left_q <= rep_left_q - 3'd1;
							if (rep_left_q == 3'd1)
								state_q <= after_rep;
						end else begin
							phase_q <= phase_q + 2'd1;
						end
					end
				end
				ST_HELD: begin
					if (adv) begin
						if (held_end)
							state_q <= after_held;
						else
							idx_q <= idx_q + 2'd1;
					end
				end
				ST_BYTE: begin
					if (adv)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: hdl/utf8_sanitize_replace.sv
// ---------------------------------------------------------------------------
// utf8_sanitize_replace
// Lenient UTF-8 sanitiser that replaces offending bytes with EF BF BD.
// ---------------------------------------------------------------------------
// Each input item is taken and its emission plan worked out, then the plan is
// loaded into the sequencer, which sends the N output items that the item
// produces (0 to 12) from the output register, one output item per cycle while
// the sink keeps ready high. The next item is taken as soon as the sequencer
// returns to idle, even while its last output item still waits in the output
// register. The final output item of a stream carries final_byte, and
// any_replaced tells whether a replacement happened anywhere in that stream.
module utf8_sanitize_replace (
	input logic          clk,
	input logic          arst_n,
	utf8s_in_if.sink     in_ch,
	utf8s_out_if.source  out_ch
);

	utf8s_pkg::utf8s_cmd_t    cmd;
	utf8s_pkg::utf8s_status_t status;

	utf8s_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.status   (status),
		.cmd      (cmd)
	);

	utf8s_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.data_byte     (in_ch.data_byte),
		.end_of_stream (in_ch.end_of_stream),
		.out_ready     (out_ch.ready),
		.out_valid     (out_ch.valid),
		.out_byte      (out_ch.out_byte),
		.final_byte    (out_ch.final_byte),
		.any_replaced  (out_ch.any_replaced)
	);

	// An item is worked on alone: after acceptance the input is closed.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> !in_ch.ready)
		else $error("input accepted twice in a row");

	a_flag_on_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.any_replaced |-> out_ch.final_byte)
		else $error("replacement flag outside the final item");

	a_plan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		status.rep_cnt <= 3'd4)
		else $error("more than four replacements planned for one item");

	a_load_only_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !status.out_stall)
		else $error("output register overwritten while stalled");

endmodule

FILE: tb/utf8_sanitize_replace_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// utf8_sanitize_replace_tb
// Self-checking bench for the UTF-8 sanitiser. A directed set of byte streams
// and then random streams, mostly well-formed text with broken sequences and
// stray bytes mixed in, are pushed through the input channel with random gaps.
// A behavioural sanitiser predicts every output item, and a monitor checks
// each one against the oldest prediction while the sink stalls at random.
// ---------------------------------------------------------------------------
module utf8_sanitize_replace_tb;

	localparam int CYCLE_LIMIT  = 600000;
	localparam int RANDOM_ITEMS = 420;
	localparam int MAX_RESULTS  = 12;
	localparam int DRAIN_CYCLES = 40;
	localparam int HOLD_CYCLES  = 400;
	localparam int HOLD_AFTER   = 160;

	// Bit 8 marks the final byte of a stream.
	localparam logic [8:0] DIRECTED [24] = '{
		9'h000, 9'h07F, 9'h0C3, 9'h0A9, 9'h0E2, 9'h082, 9'h1AC,
		9'h0F0, 9'h09F, 9'h098, 9'h080, 9'h080, 9'h0FF,
		9'h0E2, 9'h082, 9'h041,
		9'h0F0, 9'h09F, 9'h098, 9'h0FF,
		9'h0F4, 9'h08F, 9'h1BF,
		9'h1C1
	};

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_stream;
		logic       drain_first;
	} raw_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       final_byte;
		logic       any_replaced;
	} san_byte_t;

	logic clk;
	logic arst_n;

	utf8s_in_if  in_ch ();
	utf8s_out_if out_ch ();

	utf8_sanitize_replace u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	raw_item_t pending_bytes [$];
	san_byte_t expected_bytes [$];
	san_byte_t step_bytes [$];

	// Predictor state.
	logic [7:0] held [utf8s_pkg::HELD_DEPTH];
	logic [1:0] held_n;
	logic [2:0] want_len;
	logic       repl_seen;

	int  in_offered;
	int  in_accepted;
	int  tx_gap;
	int  rx_wait;
	bit  tx_idle_on;
	bit  rx_idle_on;
	bit  rx_hold;
	int  cycle_count;
	int  mismatch_count;
	int  bytes_checked;
	int  streams_done;
	int  streams_replaced;
	raw_item_t tx_item;

	function automatic int draw_gap(input bit idle_on);
		return idle_on ? int'($urandom_range(0, 19)) : 0;
	endfunction

	task automatic put_byte(input logic [7:0] b);
		if (step_bytes.size() < MAX_RESULTS)
			step_bytes.insert(step_bytes.size(),
				'{out_byte: b, final_byte: 1'b0, any_replaced: 1'b0});
	endtask

	task automatic put_replacement();
		repl_seen = 1'b1;
		put_byte(utf8s_pkg::REPL_B0);
		put_byte(utf8s_pkg::REPL_B1);
		put_byte(utf8s_pkg::REPL_B2);
	endtask

	task automatic drop_held();
		for (int k = 0; k < int'(held_n); k++)
			put_replacement();
		held_n   = '0;
		want_len = '0;
	endtask

	task automatic take_fresh(input logic [7:0] b);
		logic [2:0] len;
		len = '0;
		if (b < utf8s_pkg::ASCII_LIMIT) begin
			put_byte(b);
		end else begin
			if ((b & utf8s_pkg::LEAD2_MASK) == utf8s_pkg::LEAD2_CODE)
				len = 3'd2;
			else if ((b & utf8s_pkg::LEAD3_MASK) == utf8s_pkg::LEAD3_CODE)
				len = 3'd3;
			else if ((b & utf8s_pkg::LEAD4_MASK) == utf8s_pkg::LEAD4_CODE)
				len = 3'd4;
			if (len == 0) begin
				put_replacement();
			end else begin
				held[0]  = b;
				held_n   = 2'd1;
				want_len = len;
			end
		end
	endtask

	// Works out the output items caused by one input byte.
	task automatic sanitize_byte(input logic [7:0] b, input logic eos);
		step_bytes.delete();
		if (want_len != 0) begin
			if ((b & utf8s_pkg::CONT_MASK) == utf8s_pkg::CONT_CODE) begin
				if (int'(held_n) + 1 >= int'(want_len)) begin
					for (int k = 0; k < int'(held_n); k++)
						put_byte(held[k]);
					put_byte(b);
					held_n   = '0;
					want_len = '0;
				end else if (held_n < 2'd3) begin
					held[held_n] = b;
					held_n       = held_n + 2'd1;
				end
			end else begin
				drop_held();
				take_fresh(b);
			end
		end else begin
			take_fresh(b);
		end
		if (eos) begin
			if (want_len != 0)
				drop_held();
			if (step_bytes.size() > 0) begin
				step_bytes[step_bytes.size() - 1].final_byte   = 1'b1;
				step_bytes[step_bytes.size() - 1].any_replaced = repl_seen;
			end
			held_n    = '0;
			want_len  = '0;
			repl_seen = 1'b0;
		end
		foreach (step_bytes[i])
			expected_bytes.insert(expected_bytes.size(), step_bytes[i]);
	endtask

	task automatic note_mismatch(input string what, input san_byte_t want, input san_byte_t got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%s: expected byte %02h final %0b repl %0b, got byte %02h final %0b repl %0b",
				what, want.out_byte, want.final_byte, want.any_replaced,
				got.out_byte, got.final_byte, got.any_replaced);
	endtask

	task automatic queue_raw(input logic [7:0] b, input logic eos, input logic drain);
		pending_bytes.insert(pending_bytes.size(),
			'{data_byte: b, end_of_stream: eos, drain_first: drain});
	endtask

	task automatic add_byte(input logic [7:0] b, input logic drain);
		queue_raw(b, 1'b0, drain);
	endtask

	// Clock, reset and the starting values of every input.
	initial begin
		clk                 = 1'b0;
		arst_n              = 1'b0;
		in_ch.valid         = 1'b0;
		in_ch.data_byte     = '0;
		in_ch.end_of_stream = 1'b0;
		out_ch.ready        = 1'b0;
		fork
			forever #6 clk = ~clk;
			begin
				repeat (12) @(posedge clk);
				@(negedge clk);
				arst_n = 1'b1;
			end
		join_none
	end

	initial begin
		held_n         = '0;
		want_len       = '0;
		repl_seen      = 1'b0;
		in_offered     = 0;
		in_accepted    = 0;
		tx_gap         = 0;
		rx_wait        = 0;
		tx_idle_on     = 1'b1;
		rx_idle_on     = 1'b1;
		cycle_count    = 0;
		mismatch_count = 0;
		bytes_checked  = 0;
		streams_done   = 0;
		streams_replaced = 0;
		foreach (held[i])
			held[i] = '0;
	end

	// Stimulus: directed streams, then random streams until enough bytes are queued.
	initial begin : stimulus
		int         n_items;
		int         n_sym;
		int         kind;
		int         len;
		int         stream_idx;
		bit         drain;
		logic [7:0] lead;

		foreach (DIRECTED[i])
			queue_raw(DIRECTED[i][7:0], DIRECTED[i][8], 1'b0);
		n_items    = 0;
		stream_idx = 0;
		while (n_items < RANDOM_ITEMS) begin
			drain = (stream_idx == 15) || (stream_idx == 35);
			n_sym = $urandom_range(1, 8);
			for (int s = 0; s < n_sym; s++) begin
				kind = $urandom_range(0, 99);
				len  = $urandom_range(1, 4);
				case (len)
					1: lead = 8'($urandom_range(0, 127));
					2: lead = utf8s_pkg::LEAD2_CODE | 8'($urandom_range(0, 31));
					3: lead = utf8s_pkg::LEAD3_CODE | 8'($urandom_range(0, 15));
					default: lead = utf8s_pkg::LEAD4_CODE | 8'($urandom_range(0, 7));
				endcase
				if (kind < 70) begin
					// Well-formed symbol.
					add_byte(lead, drain);
					for (int c = 1; c < len; c++)
						add_byte(utf8s_pkg::CONT_CODE | 8'($urandom_range(0, 63)), 1'b0);
				end else if (kind < 80) begin
					// Truncated sequence, broken by whatever comes next.
					if (len == 1)
						lead = utf8s_pkg::LEAD2_CODE | 8'($urandom_range(0, 31));
					add_byte(lead, drain);
					for (int c = 2; c < len; c++)
						if ($urandom_range(0, 1))
							add_byte(utf8s_pkg::CONT_CODE | 8'($urandom_range(0, 63)),
								1'b0);
				end else if (kind < 90) begin
					if ($urandom_range(0, 1))
						add_byte(utf8s_pkg::CONT_CODE | 8'($urandom_range(0, 63)), drain);
					else
						add_byte(utf8s_pkg::LEAD4_MASK | 8'($urandom_range(0, 7)), drain);
				end else begin
					add_byte(8'($urandom_range(0, 255)), drain);
				end
				drain = 1'b0;
			end
			pending_bytes[pending_bytes.size() - 1].end_of_stream = 1'b1;
			n_items = pending_bytes.size() - $size(DIRECTED);
			stream_idx++;
		end
	end

	// Driver: one item at a time, with a random gap before each.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else if (in_accepted == in_offered) begin
			if (tx_gap > 0) begin
				in_ch.valid <= 1'b0;
				tx_gap--;
			end else if (pending_bytes.size() == 0) begin
				in_ch.valid <= 1'b0;
			end else if (pending_bytes[0].drain_first && expected_bytes.size() != 0) begin
				in_ch.valid <= 1'b0;
			end else begin
				tx_item = pending_bytes.pop_front();
				in_ch.data_byte     <= tx_item.data_byte;
				in_ch.end_of_stream <= tx_item.end_of_stream;
				in_ch.valid         <= 1'b1;
				in_offered++;
				if ($urandom_range(0, 39) == 0)
					tx_idle_on = !tx_idle_on;
				tx_gap = draw_gap(tx_idle_on);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready) begin
			sanitize_byte(in_ch.data_byte, in_ch.end_of_stream);
			in_accepted++;
		end
	end

	// Sink ready: random waits per item, and one long hold-off.
	always @(negedge clk) begin
		if (!arst_n || rx_hold) begin
			out_ch.ready <= 1'b0;
		end else if (rx_wait > 0) begin
			out_ch.ready <= 1'b0;
			rx_wait--;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	initial begin
		rx_hold = 1'b0;
		while (in_accepted < HOLD_AFTER)
			@(posedge clk);
		rx_hold = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold = 1'b0;
	end

	always @(posedge clk) begin : monitor
		san_byte_t got;
		san_byte_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = '{out_byte: out_ch.out_byte, final_byte: out_ch.final_byte,
				any_replaced: out_ch.any_replaced};
			if (expected_bytes.size() == 0) begin
				note_mismatch("unexpected item", '0, got);
			end else begin
				want = expected_bytes.pop_front();
				if (got.out_byte !== want.out_byte || got.final_byte !== want.final_byte
						|| got.any_replaced !== want.any_replaced)
					note_mismatch("wrong item", want, got);
			end
			bytes_checked++;
			if (got.final_byte === 1'b1) begin
				streams_done++;
				if (got.any_replaced === 1'b1)
					streams_replaced++;
			end
			if ($urandom_range(0, 39) == 0)
				rx_idle_on = !rx_idle_on;
			rx_wait = draw_gap(rx_idle_on);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin : finish_run
		@(posedge arst_n);
		while (pending_bytes.size() != 0 || in_accepted != in_offered)
			@(posedge clk);
		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_bytes.size() != 0) begin
			$display("%0d expected items never arrived", expected_bytes.size());
			mismatch_count += expected_bytes.size();
		end
		$display("%0d input bytes sent, %0d output bytes checked in %0d cycles",
			in_accepted, bytes_checked, cycle_count);
		$display("%0d streams closed, %0d of them with replacements, %0d mismatches",
			streams_done, streams_replaced, mismatch_count);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

FILE: filelist.f
hdl/utf8s_pkg.sv
hdl/utf8s_in_if.sv
hdl/utf8s_out_if.sv
hdl/utf8s_datapath.sv
hdl/utf8s_ctrl.sv
hdl/utf8_sanitize_replace.sv
tb/utf8_sanitize_replace_tb.sv
